// ===== design/nucleotide_triplet_packer_unit_assert.svh =====
// Assertion macros for the nucleotide triplet packer unit.
`ifndef NUCLEOTIDE_TRIPLET_PACKER_UNIT_ASSERT_SVH
`define NUCLEOTIDE_TRIPLET_PACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define NTP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define NTP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define NTP_ASSERT_ALWAYS(lbl, cond, msg)
`define NTP_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== design/ntp_pkg.sv =====
// Shared types, constants and the symbol decoder of the triplet packer.
`timescale 1ns / 1ps
`default_nettype none
package ntp_pkg;

  // Queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int SYM_W  = 8;
  localparam int DIG_W  = 3;
  localparam int RES_W  = 2;
  localparam int CODE_W = 7;
  localparam int POS_W  = 2;

  // Digit weights inside one triple
  localparam logic [CODE_W-1:0] WEIGHT_MID  = 7'd5;
  localparam logic [CODE_W-1:0] WEIGHT_HIGH = 7'd25;

  // Digit codes
  localparam logic [DIG_W-1:0] DIG_OTHER = 3'd0;
  localparam logic [DIG_W-1:0] DIG_A     = 3'd1;
  localparam logic [DIG_W-1:0] DIG_T     = 3'd2;
  localparam logic [DIG_W-1:0] DIG_C     = 3'd3;
  localparam logic [DIG_W-1:0] DIG_G     = 3'd4;

  // Digit positions inside one triple
  localparam logic [POS_W-1:0] POS_LOW  = 2'd0;
  localparam logic [POS_W-1:0] POS_MID  = 2'd1;
  localparam logic [POS_W-1:0] POS_HIGH = 2'd2;

  // Classified item as it sits in the queue
  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic             first;
    logic             last;
    logic [RES_W-1:0] residue;
  } q_entry_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Map an ASCII character to its digit, ignoring case
  function automatic logic [DIG_W-1:0] base_digit(input logic [SYM_W-1:0] ch);
    logic [DIG_W-1:0] d;
    case (ch)
      8'h41, 8'h61: d = DIG_A;
      8'h54, 8'h74: d = DIG_T;
      8'h43, 8'h63: d = DIG_C;
      8'h47, 8'h67: d = DIG_G;
      default:      d = DIG_OTHER;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/ntp_front.sv =====
// Front end: accepts input items, decodes the symbol and pushes to the queue.
`timescale 1ns / 1ps
`default_nettype none
module ntp_front (
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_symbol,
  input  wire logic                     in_first,
  input  wire logic                     in_last,
  input  wire logic [1:0]               in_length_residue,
  input  wire ntp_pkg::q_status_t       q_status,
  output logic                          push,
  output ntp_pkg::q_entry_t             push_data
);
  import ntp_pkg::*;

  // Stall the source only while the queue is full
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classify the item
  always_comb begin
    push_data.digit   = base_digit(in_symbol);
    push_data.first   = in_first;
    push_data.last    = in_last;
    push_data.residue = in_length_residue;
  end

endmodule
`default_nettype wire

// ===== design/ntp_queue.sv =====
// Short register queue between the front end and the packer.
`timescale 1ns / 1ps
`default_nettype none
module ntp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ntp_pkg::q_entry_t    push_data,
  input  wire logic                 pop,
  output ntp_pkg::q_entry_t         head,
  output ntp_pkg::q_status_t        status
);
  import ntp_pkg::*;

  q_entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/ntp_back.sv =====
// Back end: packs digits into triples, emits header and code items.
`timescale 1ns / 1ps
`default_nettype none
module ntp_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ntp_pkg::q_entry_t    head,
  input  wire ntp_pkg::q_status_t   q_status,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [6:0]                out_code,
  output logic                      out_is_header,
  output logic                      out_last_of_run
);
  import ntp_pkg::*;

  logic [CODE_W-1:0] sum_r, sum_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              hdr_done_r, hdr_done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              is_header_r, is_header_nxt;
  logic              last_r, last_nxt;

  logic              head_valid, load_ok, need_hdr, emit_code;
  logic [CODE_W-1:0] sum_base, term, sum_new;
  logic [POS_W-1:0]  pos_base;

  assign head_valid = !q_status.empty;
  assign load_ok    = !out_valid_r || !out_stall;
  assign need_hdr   = head.first && !hdr_done_r;

  // Restart the triple on a first item
  assign sum_base = head.first ? '0 : sum_r;
  assign pos_base = head.first ? POS_LOW : pos_r;

  // Weight the digit by its place in the triple
  always_comb begin
    case (pos_base)
      POS_LOW: term = CODE_W'(head.digit);
      POS_MID: term = CODE_W'(head.digit) * WEIGHT_MID;
      default: term = CODE_W'(head.digit) * WEIGHT_HIGH;
    endcase
  end

  assign sum_new   = sum_base + term;
  assign emit_code = (pos_base == POS_HIGH) || head.last;

  // Sequence header first, then the packed code
  always_comb begin
    pop           = 1'b0;
    sum_nxt       = sum_r;
    pos_nxt       = pos_r;
    hdr_done_nxt  = hdr_done_r;
    code_nxt      = code_r;
    is_header_nxt = is_header_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (head_valid) begin
      if (need_hdr) begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          code_nxt      = CODE_W'(head.residue) + 1'b1;
          is_header_nxt = 1'b1;
          last_nxt      = 1'b0;
          hdr_done_nxt  = 1'b1;
        end
      end else if (emit_code) begin
        if (load_ok) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          code_nxt      = sum_new + 1'b1;
          is_header_nxt = 1'b0;
          last_nxt      = head.last;
          sum_nxt       = '0;
          pos_nxt       = POS_LOW;
          hdr_done_nxt  = 1'b0;
        end
      end else begin
        // No result: fold the digit in and drop the item
        pop          = 1'b1;
        sum_nxt      = sum_new;
        pos_nxt      = pos_base + 1'b1;
        hdr_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      pos_r       <= POS_LOW;
      hdr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      pos_r       <= pos_nxt;
      hdr_done_r  <= hdr_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output payload
  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    is_header_r <= is_header_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code        = code_r;
  assign out_is_header   = is_header_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire

// ===== design/nucleotide_triplet_packer_unit.sv =====
// Top level of the nucleotide triplet packer.
//
// Input channel (in_valid / in_stall): one ASCII DNA character per item, with
// first and last flags and the length residue sampled on first. Output channel
// (out_valid / out_stall): code bytes; a header item (residue+1, is_header=1)
// leads each sequence, then one packed item 1+d0+5*d1+25*d2 per triple, the
// last one marked last_of_run and padded with zero digits.
// A front end decodes characters into a four-entry queue; a back end packs them
// into a registered output stage.
// An accepted item passes through the queue and then the registered output
// stage; the code that follows a header is loaded once the header is taken.
// Throughput: one item per cycle while out_stall is low; an item that starts a
// sequence is handled as header then digit, and the queue absorbs the delay.
// Reset clears the packing state, the queue and the output stage.
// When the receiver stalls, the output item holds, the queue fills and
// in_stall rises once its four entries are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "nucleotide_triplet_packer_unit_assert.svh"
module nucleotide_triplet_packer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_first,
  input  wire logic       in_last,
  input  wire logic [1:0] in_length_residue,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [6:0]      out_code,
  output logic            out_is_header,
  output logic            out_last_of_run
);
  import ntp_pkg::*;

  q_status_t q_status;
  q_entry_t  push_data, head;
  logic      push, pop;

  ntp_front u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol         (in_symbol),
    .in_first          (in_first),
    .in_last           (in_last),
    .in_length_residue (in_length_residue),
    .q_status          (q_status),
    .push              (push),
    .push_data         (push_data)
  );

  ntp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ntp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code        (out_code),
    .out_is_header   (out_is_header),
    .out_last_of_run (out_last_of_run)
  );

  // A header never closes a run
  `NTP_ASSERT_IMPLY(a_hdr_not_last, out_valid && out_is_header, !out_last_of_run, "header marked last")
  // Codes stay in 1..125
  `NTP_ASSERT_IMPLY(a_code_range, out_valid, (out_code != 7'd0) && (out_code <= 7'd125), "code range")
  // An empty queue never stalls the source
  `NTP_ASSERT_IMPLY(a_empty_no_stall, q_status.empty, !in_stall, "stall with empty queue")
  // The back end never pops an empty queue
  `NTP_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_status.empty), "pop from empty queue")

endmodule
`default_nettype wire

// ===== verif/tb_nucleotide_triplet_packer_unit.sv =====
// Self-checking testbench for the nucleotide triplet packer unit.
`timescale 1ns / 1ps
module tb_nucleotide_triplet_packer_unit;
  import ntp_pkg::*;

  localparam int RANDOM_ITEMS = 1630;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int PREDICTED    = -1;

  // Idle profiles for the two sides
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_SHORT = 1;
  localparam int IDLE_FULL  = 2;

  localparam logic [63:0] BASE_CHARS = "ACGTacgt";

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              is_header;
    logic              last_of_run;
  } code_item_t;

  localparam code_item_t NO_CODE = '0;

  // One input item plus the results typed in for it, if any
  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             first;
    logic             last;
    logic [RES_W-1:0] length_residue;
    int               n_typed;
    code_item_t       typed0;
    code_item_t       typed1;
  } char_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_symbol;
  logic             in_first;
  logic             in_last;
  logic [1:0]       in_length_residue;
  logic             out_valid;
  logic             out_stall;
  logic [6:0]       out_code;
  logic             out_is_header;
  logic             out_last_of_run;

  char_row_t        cur_row;
  char_row_t        directed_rows[$];
  code_item_t       expected_codes[$];
  logic [CODE_W-1:0] triple_sum;
  logic [POS_W-1:0]  triple_fill;
  int               mismatches;
  int               quiet_cycles;
  int               in_idle_mode;
  int               out_idle_mode;

  nucleotide_triplet_packer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol         (in_symbol),
    .in_first          (in_first),
    .in_last           (in_last),
    .in_length_residue (in_length_residue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code          (out_code),
    .out_is_header     (out_is_header),
    .out_last_of_run   (out_last_of_run)
  );

  always #5 clk = ~clk;

  // Map a character to its base digit, case-insensitive
  function automatic logic [DIG_W-1:0] base_of(input logic [SYM_W-1:0] ch);
    logic [SYM_W-1:0] low;
    low = ch | 8'h20;
    if (low == "a") return DIG_A;
    if (low == "t") return DIG_T;
    if (low == "c") return DIG_C;
    if (low == "g") return DIG_G;
    return DIG_OTHER;
  endfunction

  // Advance the packing state by one item; return the number of codes produced
  function automatic int pack_char(input char_row_t it, output code_item_t r0,
                                   output code_item_t r1);
    logic [DIG_W-1:0]  dig;
    logic [CODE_W-1:0] weight;
    code_item_t        packed_code;
    int                n;
    n = 0;
    r0 = NO_CODE;
    r1 = NO_CODE;
    dig = base_of(it.symbol);
    // A first item drops any open triple and leads with the header
    if (it.first) begin
      triple_sum = '0;
      triple_fill = POS_LOW;
      r0 = '{code: CODE_W'(it.length_residue) + 7'd1, is_header: 1'b1, last_of_run: 1'b0};
      n = 1;
    end
    case (triple_fill)
      POS_LOW: weight = 7'd1;
      POS_MID: weight = WEIGHT_MID;
      default: weight = WEIGHT_HIGH;
    endcase
    triple_sum = triple_sum + CODE_W'(dig) * weight;
    if (triple_fill == POS_HIGH || it.last) begin
      packed_code = '{code: triple_sum + 7'd1, is_header: 1'b0, last_of_run: it.last};
      if (n == 0) r0 = packed_code;
      else r1 = packed_code;
      n++;
      triple_sum = '0;
      triple_fill = POS_LOW;
    end else begin
      triple_fill = triple_fill + 2'd1;
    end
    return n;
  endfunction

  function automatic int draw_gap(input int mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_SHORT: return $urandom_range(0, 2);
      default:    return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic void add_row(input logic [7:0] sym, input logic first,
                                  input logic last, input logic [1:0] res,
                                  input int n, input code_item_t e0, input code_item_t e1);
    char_row_t row;
    row.symbol = sym;
    row.first = first;
    row.last = last;
    row.length_residue = res;
    row.n_typed = n;
    row.typed0 = e0;
    row.typed1 = e1;
    directed_rows.push_back(row);
  endfunction

  // Offer one item after a random gap; return once it is accepted
  task automatic send_char(input char_row_t row);
    int gap;
    gap = draw_gap(in_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_symbol <= row.symbol;
    in_first <= row.first;
    in_last <= row.last;
    in_length_residue <= row.length_residue;
    cur_row <= row;
    do @(posedge clk); while (in_stall);
  endtask

  // Check results, predict accepted items and watch for a hang
  always @(posedge clk) begin : scoreboard
    code_item_t got;
    code_item_t want;
    code_item_t p0;
    code_item_t p1;
    int         n;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{code: out_code, is_header: out_is_header, last_of_run: out_last_of_run};
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected item: code=%0d hdr=%0b last=%0b",
                     got.code, got.is_header, got.last_of_run);
        end else begin
          want = expected_codes.pop_front();
          if (got.code !== want.code || got.is_header !== want.is_header ||
              got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected code=%0d hdr=%0b last=%0b, got code=%0d hdr=%0b last=%0b",
                       want.code, want.is_header, want.last_of_run,
                       got.code, got.is_header, got.last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n = pack_char(cur_row, p0, p1);
        // Typed rows override the computed codes
        if (cur_row.n_typed != PREDICTED) begin
          n = cur_row.n_typed;
          p0 = cur_row.typed0;
          p1 = cur_row.typed1;
        end
        if (n > 0) expected_codes.push_back(p0);
        if (n > 1) expected_codes.push_back(p1);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("nucleotide_triplet_packer_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: stall a random number of cycles ahead of each item
  initial begin : receiver
    int gap;
    out_stall <= 1'b0;
    out_idle_mode = IDLE_FULL;
    forever begin
      if ($urandom_range(0, 39) == 0) out_idle_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
      gap = draw_gap(out_idle_mode);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    char_row_t row;
    int        sent;
    int        seq_len;
    int        kind;
    logic [1:0] res;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_symbol <= '0;
    in_first <= 1'b0;
    in_last <= 1'b0;
    in_length_residue <= '0;
    mismatches = 0;
    quiet_cycles = 0;
    triple_sum = '0;
    triple_fill = POS_LOW;
    in_idle_mode = IDLE_NONE;

    // Directed rows: reset state, extremes and the corner cases
    add_row("A", 0, 0, 0, 0, NO_CODE, NO_CODE);
    add_row("T", 0, 0, 3, 0, NO_CODE, NO_CODE);
    add_row("C", 0, 0, 0, 1, {7'd87, 1'b0, 1'b0}, NO_CODE);
    add_row("G", 1, 1, 1, 2, {7'd2, 1'b1, 1'b0}, {7'd5, 1'b0, 1'b1});
    add_row("g", 1, 0, 3, 1, {7'd4, 1'b1, 1'b0}, NO_CODE);
    add_row("g", 0, 0, 0, 0, NO_CODE, NO_CODE);
    add_row("G", 0, 0, 0, 1, {7'd125, 1'b0, 1'b0}, NO_CODE);
    add_row("x", 0, 1, 0, 1, {7'd1, 1'b0, 1'b1}, NO_CODE);
    add_row(8'h00, 1, 0, 0, 1, {7'd1, 1'b1, 1'b0}, NO_CODE);
    add_row(8'hFF, 0, 0, 2, 0, NO_CODE, NO_CODE);
    add_row("t", 1, 0, 2, 1, {7'd3, 1'b1, 1'b0}, NO_CODE);
    add_row("a", 0, 0, 0, 0, NO_CODE, NO_CODE);
    add_row("c", 0, 1, 0, 1, {7'd83, 1'b0, 1'b1}, NO_CODE);
    add_row("T", 1, 0, 2, 1, {7'd3, 1'b1, 1'b0}, NO_CODE);
    add_row("A", 0, 1, 1, 1, {7'd8, 1'b0, 1'b1}, NO_CODE);
    add_row("c", 1, 1, 3, 2, {7'd4, 1'b1, 1'b0}, {7'd4, 1'b0, 1'b1});
    add_row(8'hC1, 1, 0, 0, PREDICTED, NO_CODE, NO_CODE);
    add_row("@", 0, 0, 3, PREDICTED, NO_CODE, NO_CODE);
    add_row("t", 0, 0, 1, PREDICTED, NO_CODE, NO_CODE);
    add_row(8'hE7, 0, 0, 2, PREDICTED, NO_CODE, NO_CODE);
    add_row("[", 0, 1, 0, PREDICTED, NO_CODE, NO_CODE);
    add_row("C", 1, 0, 2, PREDICTED, NO_CODE, NO_CODE);
    add_row("g", 0, 1, 1, PREDICTED, NO_CODE, NO_CODE);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      in_idle_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
      send_char(directed_rows[i]);
    end

    // Random part: mostly well-formed sequences, some broken ones
    row.n_typed = PREDICTED;
    row.typed0 = NO_CODE;
    row.typed1 = NO_CODE;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) in_idle_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
      kind = $urandom_range(0, 11);
      seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      res = 2'(seq_len % 3);
      if (kind == 0) res = 2'($urandom_range(0, 3));
      for (int i = 0; i < seq_len; i++) begin
        if ($urandom_range(0, 4) == 0) row.symbol = 8'($urandom_range(0, 255));
        else row.symbol = BASE_CHARS[8 * $urandom_range(0, 7) +: 8];
        // kind 1 drops first, kind 2 drops last, kind 3 scatters both
        row.first = (i == 0) && kind != 1;
        row.last = (i == seq_len - 1) && kind != 2;
        if (kind == 3) begin
          row.first = ($urandom_range(0, 5) == 0);
          row.last = ($urandom_range(0, 5) == 0);
        end
        row.length_residue = row.first ? res : 2'($urandom_range(0, 3));
        send_char(row);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding codes, then let the pipeline settle
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("nucleotide_triplet_packer_unit regression: pass");
    end else begin
      $display("nucleotide_triplet_packer_unit regression: fail");
    end
    $finish;
  end

endmodule
